>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is high.
`define SFR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property checked in every cycle, reset included.
`define SFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/sfr_pkg.sv
package sfr_pkg;

  localparam int ADDR_BYTES = 6;
  localparam int STATION_W  = 48;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] SUM_TOP   = 8'hFF;

  // result kinds
  localparam logic [2:0] KIND_PAYLOAD = 3'd0;
  localparam logic [2:0] KIND_GOOD    = 3'd1;
  localparam logic [2:0] KIND_BAD_SUM = 3'd2;
  localparam logic [2:0] KIND_REJECT  = 3'd3;
  localparam logic [2:0] KIND_TIMEOUT = 3'd4;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_EXP_LEN    = 2'd0;
  localparam logic [1:0] REG_FAST_MODE  = 2'd1;
  localparam logic [1:0] REG_HUNT_LIMIT = 2'd2;

  localparam logic [15:0] EXP_LEN_RST    = 16'd204;
  localparam logic [15:0] HUNT_LIMIT_RST = 16'd512;

  typedef struct packed {
    logic [15:0] expected_length;
    logic        fast_mode;
    logic [15:0] hunt_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]           kind;
    logic [7:0]           data;
    logic [15:0]          byte_index;
    logic [STATION_W-1:0] station_address;
  } result_t;

endpackage

>>> rtl/core/sfr_cfg_regs.sv
module sfr_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output sfr_pkg::cfg_t      cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_length <= sfr_pkg::EXP_LEN_RST;
      cfg.fast_mode       <= 1'b0;
      cfg.hunt_limit      <= sfr_pkg::HUNT_LIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        sfr_pkg::REG_EXP_LEN:    cfg.expected_length <= pwdata[15:0];
        sfr_pkg::REG_FAST_MODE:  cfg.fast_mode       <= pwdata[0];
        sfr_pkg::REG_HUNT_LIMIT: cfg.hunt_limit      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sfr_pkg::REG_EXP_LEN:    prdata = {16'd0, cfg.expected_length};
      sfr_pkg::REG_FAST_MODE:  prdata = {31'd0, cfg.fast_mode};
      sfr_pkg::REG_HUNT_LIMIT: prdata = {16'd0, cfg.hunt_limit};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/core/sfr_parser.sv
module sfr_parser (
  input  logic              clk,
  input  logic              rst,
  input  sfr_pkg::cfg_t     cfg,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output logic              hit,
  output sfr_pkg::result_t  res
);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_LEN_LO  = 3'd1;
  localparam logic [2:0] PH_LEN_HI  = 3'd2;
  localparam logic [2:0] PH_ADDR    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_CHECK   = 3'd5;

  // the address field is always six bytes, kept whole as the 48-bit station address
  logic [2:0]                    phase, phase_next;
  logic [15:0]                   hunt_count, hunt_count_next;
  logic [15:0]                   frame_length, frame_length_next;
  logic [sfr_pkg::STATION_W-1:0] address_reg, address_reg_next;
  logic [15:0]                   position, position_next;
  logic [7:0]                    running_sum, running_sum_next;
  logic [15:0]                   pos_inc;
  logic [7:0]                    want;

  assign pos_inc = position + 16'd1;
  assign want    = sfr_pkg::SUM_TOP - running_sum;

  always_comb begin
    phase_next        = phase;
    hunt_count_next   = hunt_count;
    frame_length_next = frame_length;
    address_reg_next  = address_reg;
    position_next     = position;
    running_sum_next  = running_sum;
    hit               = 1'b0;
    res.kind            = sfr_pkg::KIND_PAYLOAD;
    res.data            = 8'd0;
    res.byte_index      = 16'd0;
    res.station_address = address_reg;

    unique case (phase)
      PH_HUNT: begin
        if (!cfg.fast_mode && (hunt_count >= cfg.hunt_limit)) begin
          // timeout eats this byte, even a sync byte
          hunt_count_next     = 16'd0;
          hit                 = 1'b1;
          res.kind            = sfr_pkg::KIND_TIMEOUT;
          res.station_address = '0;
        end else begin
          if (!cfg.fast_mode) hunt_count_next = hunt_count + 16'd1;
          if (rx_byte == sfr_pkg::SYNC_BYTE) begin
            phase_next        = PH_LEN_LO;
            frame_length_next = 16'd0;
            address_reg_next  = '0;
            position_next     = 16'd0;
            running_sum_next  = 8'd0;
          end
        end
      end
      PH_LEN_LO: begin
        frame_length_next = {8'd0, rx_byte};
        phase_next        = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frame_length_next = {rx_byte, frame_length[7:0]};
        position_next     = 16'd0;
        phase_next        = PH_ADDR;
      end
      PH_ADDR: begin
        address_reg_next = {address_reg[sfr_pkg::STATION_W-9:0], rx_byte};
        position_next    = pos_inc;
        if (pos_inc >= 16'(sfr_pkg::ADDR_BYTES)) begin
          position_next    = 16'd0;
          running_sum_next = 8'd0;
          if (frame_length != cfg.expected_length) begin
            phase_next          = PH_HUNT;
            hunt_count_next     = 16'd0;
            hit                 = 1'b1;
            res.kind            = sfr_pkg::KIND_REJECT;
            res.byte_index      = frame_length;
            res.station_address = address_reg_next;
          end else begin
            phase_next = (frame_length == 16'd0) ? PH_CHECK : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        hit              = 1'b1;
        res.kind         = sfr_pkg::KIND_PAYLOAD;
        res.data         = rx_byte;
        res.byte_index   = position;
        running_sum_next = running_sum + rx_byte;
        position_next    = pos_inc;
        if (pos_inc >= frame_length) phase_next = PH_CHECK;
      end
      PH_CHECK: begin
        phase_next      = PH_HUNT;
        hunt_count_next = 16'd0;
        hit             = 1'b1;
        res.kind        = (rx_byte == want) ? sfr_pkg::KIND_GOOD : sfr_pkg::KIND_BAD_SUM;
        res.data        = rx_byte;
        res.byte_index  = frame_length;
      end
      default: begin
        phase_next      = PH_HUNT;
        hunt_count_next = 16'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      hunt_count   <= 16'd0;
      frame_length <= 16'd0;
      address_reg  <= '0;
      position     <= 16'd0;
      running_sum  <= 8'd0;
    end else if (step) begin
      phase        <= phase_next;
      hunt_count   <= hunt_count_next;
      frame_length <= frame_length_next;
      address_reg  <= address_reg_next;
      position     <= position_next;
      running_sum  <= running_sum_next;
    end
  end

endmodule

>>> rtl/core/serial_frame_receiver.sv
// Channel  Handshake          Payload                                  Role
// rx       rx_valid/rx_ready  rx_byte[7:0]                             received bytes in
// res      res_valid/res_ready kind[2:0] data[7:0] byte_index[15:0]    results out
//                             station_address[47:0]
// cfg      psel/penable/pwrite paddr[3:0] pwdata/prdata[31:0] pready   register access
//
// One byte per cycle sustained while res_ready stays high; a byte passes through the input
// register and the parser into the result register before its result is valid.
// The rate is set by the parser update between the input and result registers.
// rst is synchronous, active high: parser back to hunting, registers to reset values.
// A stalled result holds the input register; rx_ready drops only when both stages are full.
module serial_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  // results
  output logic        res_valid,
  input  logic        res_ready,
  output logic [2:0]  kind,
  output logic [7:0]  data,
  output logic [15:0] byte_index,
  output logic [47:0] station_address,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sfr_pkg::cfg_t    cfg;
  sfr_pkg::result_t step_res;
  sfr_pkg::result_t res_q;
  logic             step_hit;

  // input register
  logic       in_full;
  logic [7:0] in_byte;
  // the held byte moves through the parser when the result slot is free
  logic       step;

  assign step     = in_full & (~res_valid | res_ready);
  assign rx_ready = ~in_full | step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (rx_valid && rx_ready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      in_byte <= rx_byte;
    end
  end

  sfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (step),
    .rx_byte (in_byte),
    .hit     (step_hit),
    .res     (step_res)
  );

  // result register; bytes that make no result leave it empty
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= step_hit;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && step_hit) begin
      res_q <= step_res;
    end
  end

  assign kind            = res_q.kind;
  assign data            = res_q.data;
  assign byte_index      = res_q.byte_index;
  assign station_address = res_q.station_address;

endmodule

>>> rtl/core/sfr_checker.sv
`include "assert_macros.svh"

module sfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  kind,
  input logic [7:0]  data,
  input logic [15:0] byte_index,
  input logic [47:0] station_address
);

  logic        stalled;
  logic [71:0] body;
  logic [74:0] fields;
  logic        is_timeout;
  logic        is_reject;

  assign stalled    = res_valid & ~res_ready;
  assign body       = {data, byte_index, station_address};
  assign fields     = {kind, body};
  assign is_timeout = res_valid && (kind == sfr_pkg::KIND_TIMEOUT);
  assign is_reject  = res_valid && (kind == sfr_pkg::KIND_REJECT);

  `SFR_ASSERT(a_res_hold, clk, rst, stalled |=> res_valid && $stable(fields), "held result changed")
  `SFR_ASSERT(a_kind_range, clk, rst, res_valid |-> kind <= sfr_pkg::KIND_TIMEOUT, "kind out of range")
  `SFR_ASSERT(a_timeout_zero, clk, rst, is_timeout |-> body == '0, "timeout fields not zero")
  `SFR_ASSERT(a_reject_data, clk, rst, is_reject |-> data == 8'd0, "length reject carries data")
  `SFR_ASSERT_ALWAYS(a_reset_clears, clk, $past(rst) |-> !res_valid, "valid right after reset")

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (res_valid),
  .res_ready       (res_ready),
  .kind            (kind),
  .data            (data),
  .byte_index      (byte_index),
  .station_address (station_address)
);
